>>> design/firrs_pkg.sv
// Shared types and constants for the round-and-saturate FIR filter.
package firrs_pkg;

    localparam int DEF_TAPS           = 256;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_COEF_FRAC_BITS = 15;
    localparam int IDX_BITS           = 8;
    localparam int TAP_COUNT_BITS     = 9;
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_COEF   = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [IDX_BITS-1:0]   index;
        logic                  last;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_MAC,
        BK_DONE
    } t_back_state;

endpackage

>>> design/firrs_in_if.sv
// Request channel: one sample or one coefficient write per request.
interface firrs_in_if #(
    parameter int SAMPLE_BITS = firrs_pkg::DEF_SAMPLE_BITS
);
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic [firrs_pkg::IDX_BITS-1:0]        coef_index;
    logic signed [SAMPLE_BITS-1:0]         value;
    logic                                  block_last;

    modport source (output valid, func, coef_index, value, block_last, input ready);
    modport sink   (input valid, func, coef_index, value, block_last, output ready);
endinterface

>>> design/firrs_out_if.sv
// Result channel: one filtered sample per sample request.
interface firrs_out_if #(
    parameter int SAMPLE_BITS = firrs_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;

    modport source (output valid, filtered, saturated, input ready);
    modport sink   (input valid, filtered, saturated, output ready);
endinterface

>>> design/fir_filter_round_saturate.sv
// Direct-form FIR filter, round half up and saturate, one shared multiply-accumulate.
// Usage:
//   i_req carries requests: func 0 filters the sample in value, func 1 writes value
//   (low COEF_FRAC_BITS+1 bits, signed) as coefficient coef_index; indexes at or
//   beyond TAPS are dropped. block_last on a sample clears the history after it.
//   o_rsp returns one result per sample: filtered and the saturated flag.
//   i_cfg_we/i_cfg_wdata set the tap count; write it only while the block is idle.
// Processing:
//   A result is loaded into the output register once the MAC pass over N taps ends, N
//   being the tap count clipped to TAPS; the single multiply-accumulate unit steps
//   one tap per cycle and starts the next sample only after that result is loaded.
//   A coefficient write produces no result.
//   A two-entry command queue sits between request side and the MAC engine.
// Reset:
//   Synchronous, active low. Afterwards the coefficient store is zeroed by a
//   clearing pass over all TAPS entries, during which i_req.ready is low. Tap count
//   resets to TAPS and the history starts empty.
// Stalls:
//   A result waits in the output register while o_rsp.ready is low; the engine
//   finishes the next sample and then holds until the register is free.
module fir_filter_round_saturate #(
    parameter int TAPS           = firrs_pkg::DEF_TAPS,
    parameter int SAMPLE_BITS    = firrs_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = firrs_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [firrs_pkg::TAP_COUNT_BITS-1:0] i_cfg_wdata,
    firrs_in_if.sink                            i_req,
    firrs_out_if.source                         o_rsp
);

    localparam int CW  = COEF_FRAC_BITS + 1;
    localparam int DW  = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW;
    localparam int KW  = $clog2(TAPS + 1);
    localparam int TCW = (KW > firrs_pkg::TAP_COUNT_BITS) ? KW : firrs_pkg::TAP_COUNT_BITS;

    logic [TCW-1:0]   r_tap_count;
    logic             s_push, s_pop, s_q_vld, s_q_full, s_clearing;
    firrs_pkg::t_cmd  s_push_cmd, s_head_cmd;
    logic [DW-1:0]    s_push_data, s_head_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TCW'(TAPS);
        end else if (i_cfg_we) begin
            r_tap_count <= TCW'(i_cfg_wdata);
        end
    end

    firrs_front #(
        .TAPS           (TAPS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .i_req      (i_req),
        .i_clearing (s_clearing),
        .i_q_full   (s_q_full),
        .o_push     (s_push),
        .o_cmd      (s_push_cmd),
        .o_data     (s_push_data)
    );

    firrs_queue #(
        .DW    (DW),
        .DEPTH (firrs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_cmd   (s_push_cmd),
        .i_data  (s_push_data),
        .i_pop   (s_pop),
        .o_vld   (s_q_vld),
        .o_full  (s_q_full),
        .o_cmd   (s_head_cmd),
        .o_data  (s_head_data)
    );

    firrs_back #(
        .TAPS           (TAPS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .TCW            (TCW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tap_count (r_tap_count),
        .i_cmd_vld   (s_q_vld),
        .i_cmd       (s_head_cmd),
        .i_cmd_data  (s_head_data),
        .o_cmd_pop   (s_pop),
        .o_clearing  (s_clearing),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTH
    a_no_req_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> !s_clearing)
        else $error("request accepted during coefficient clearing");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |-> !s_q_full)
        else $error("command queue overflow");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> s_q_vld)
        else $error("command queue underflow");
`endif

endmodule

>>> design/firrs_front.sv
// Front end: takes requests, drops out-of-range coefficient writes, formats commands.
module firrs_front #(
    parameter int TAPS           = firrs_pkg::DEF_TAPS,
    parameter int SAMPLE_BITS    = firrs_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = firrs_pkg::DEF_COEF_FRAC_BITS,
    localparam int CW            = COEF_FRAC_BITS + 1,
    localparam int DW            = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW
) (
    firrs_in_if.sink           i_req,
    input  logic               i_clearing,
    input  logic               i_q_full,
    output logic               o_push,
    output firrs_pkg::t_cmd    o_cmd,
    output logic [DW-1:0]      o_data
);

    logic [DW-1:0]  s_raw;
    logic           s_in_range;
    logic           s_is_coef;

    assign i_req.ready = !i_clearing && !i_q_full;

    assign s_is_coef  = (i_req.func == firrs_pkg::CMD_COEF);
    assign s_in_range = (32'(i_req.coef_index) < 32'(TAPS));
    // coefficient is the low CW bits of the raw field, sign extended
    assign s_raw      = DW'($unsigned(i_req.value));

    always_comb begin
        o_cmd.kind  = firrs_pkg::t_cmd_kind'(i_req.func);
        o_cmd.index = i_req.coef_index;
        o_cmd.last  = i_req.block_last;
        if (s_is_coef) begin
            o_data = DW'($signed(s_raw[CW-1:0]));
        end else begin
            o_data = DW'(i_req.value);
        end
        o_push = i_req.valid && i_req.ready && (!s_is_coef || s_in_range);
    end

endmodule

>>> design/firrs_queue.sv
// Short command queue between front end and back end.
module firrs_queue #(
    parameter int DW    = firrs_pkg::DEF_SAMPLE_BITS,
    parameter int DEPTH = firrs_pkg::QUEUE_DEPTH,
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  firrs_pkg::t_cmd    i_cmd,
    input  logic [DW-1:0]      i_data,
    input  logic               i_pop,
    output logic               o_vld,
    output logic               o_full,
    output firrs_pkg::t_cmd    o_cmd,
    output logic [DW-1:0]      o_data
);

    firrs_pkg::t_cmd  r_cmd  [DEPTH];
    logic [DW-1:0]    r_data [DEPTH];
    logic [PTRW-1:0]  r_wptr;
    logic [PTRW-1:0]  r_rptr;
    logic [CNTW-1:0]  r_count;

    assign o_vld  = (r_count != '0);
    assign o_full = (r_count == CNTW'(DEPTH));
    assign o_cmd  = r_cmd[r_rptr];
    assign o_data = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wptr]  <= i_cmd;
            r_data[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTRW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTRW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/firrs_back.sv
// Back end: coefficient/history stores, shared multiply-accumulate, round and saturate.
module firrs_back #(
    parameter int TAPS           = firrs_pkg::DEF_TAPS,
    parameter int SAMPLE_BITS    = firrs_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = firrs_pkg::DEF_COEF_FRAC_BITS,
    parameter int TCW            = firrs_pkg::TAP_COUNT_BITS,
    localparam int CW            = COEF_FRAC_BITS + 1,
    localparam int DW            = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW,
    localparam int AW            = $clog2(TAPS),
    localparam int KW            = $clog2(TAPS + 1),
    localparam int PW            = SAMPLE_BITS + CW,
    localparam int ACCW          = PW + AW + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [TCW-1:0]     i_tap_count,
    input  logic               i_cmd_vld,
    input  firrs_pkg::t_cmd    i_cmd,
    input  logic [DW-1:0]      i_cmd_data,
    output logic               o_cmd_pop,
    output logic               o_clearing,
    firrs_out_if.source        o_rsp
);

    localparam logic signed [ACCW-1:0] HALF = ACCW'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [ACCW-1:0] QMAX = ACCW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [ACCW-1:0] QMIN = ~QMAX;

    firrs_pkg::t_back_state r_state, n_state;

    logic signed [CW-1:0]          r_coef_mem [TAPS];
    logic signed [SAMPLE_BITS-1:0] r_hist_mem [TAPS];

    logic [AW-1:0]  r_clr_addr;
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rdptr;
    logic [AW-1:0]  r_fill;
    logic [KW-1:0]  r_k;
    logic [KW-1:0]  r_n;
    logic           r_last;
    logic           r_p1_vld, r_p1_ok, r_p2_vld;
    logic signed [CW-1:0]          r_coef_rd;
    logic signed [SAMPLE_BITS-1:0] r_hist_rd;
    logic signed [PW-1:0]          r_prod;
    logic signed [ACCW-1:0]        r_acc;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filtered;
    logic                          r_saturated;

    logic                 s_coef_we, s_hist_we, s_start, s_issue, s_load, s_pop;
    logic [AW-1:0]        s_coef_waddr;
    logic signed [CW-1:0] s_coef_wdata;
    logic [KW-1:0]        s_n;
    logic signed [PW-1:0]   s_mult;
    logic signed [ACCW-1:0] s_rnd, s_q, s_clip;
    logic                   s_sat;

    assign o_cmd_pop      = s_pop;
    assign o_clearing     = (r_state == firrs_pkg::BK_CLEAR);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.filtered = r_filtered;
    assign o_rsp.saturated = r_saturated;

    assign s_n = (32'(i_tap_count) > 32'(TAPS)) ? KW'(TAPS) : KW'(i_tap_count);
    assign s_mult = $signed(r_coef_rd) * $signed(r_hist_rd);

    // floor(acc / 2^F + 1/2), then clip
    assign s_rnd = r_acc + HALF;
    assign s_q   = s_rnd >>> COEF_FRAC_BITS;
    always_comb begin
        s_sat  = 1'b0;
        s_clip = s_q;
        if (s_q > QMAX) begin
            s_clip = QMAX;
            s_sat  = 1'b1;
        end else if (s_q < QMIN) begin
            s_clip = QMIN;
            s_sat  = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            firrs_pkg::BK_CLEAR: begin
                if (r_clr_addr == AW'(TAPS - 1)) n_state = firrs_pkg::BK_IDLE;
            end
            firrs_pkg::BK_IDLE: begin
                if (i_cmd_vld && i_cmd.kind == firrs_pkg::CMD_SAMPLE) begin
                    n_state = firrs_pkg::BK_MAC;
                end
            end
            firrs_pkg::BK_MAC: begin
                if (r_k == r_n && !r_p1_vld && !r_p2_vld) n_state = firrs_pkg::BK_DONE;
            end
            firrs_pkg::BK_DONE: begin
                if (!r_out_valid || o_rsp.ready) n_state = firrs_pkg::BK_IDLE;
            end
            default: n_state = firrs_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        s_pop        = 1'b0;
        s_coef_we    = 1'b0;
        s_coef_waddr = r_clr_addr;
        s_coef_wdata = '0;
        s_hist_we    = 1'b0;
        s_start      = 1'b0;
        s_issue      = 1'b0;
        s_load       = 1'b0;
        case (r_state)
            firrs_pkg::BK_CLEAR: begin
                s_coef_we = 1'b1;
            end
            firrs_pkg::BK_IDLE: begin
                if (i_cmd_vld) begin
                    s_pop = 1'b1;
                    if (i_cmd.kind == firrs_pkg::CMD_COEF) begin
                        s_coef_we    = 1'b1;
                        s_coef_waddr = AW'(i_cmd.index);
                        s_coef_wdata = i_cmd_data[CW-1:0];
                    end else begin
                        s_hist_we = 1'b1;
                        s_start   = 1'b1;
                    end
                end
            end
            firrs_pkg::BK_MAC: begin
                s_issue = (r_k != r_n);
            end
            firrs_pkg::BK_DONE: begin
                s_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
                s_pop = 1'b0;
            end
        endcase
    end

    // stores, read data registered
    always_ff @(posedge i_clk) begin
        if (s_coef_we) r_coef_mem[s_coef_waddr] <= s_coef_wdata;
        if (s_hist_we) r_hist_mem[r_wptr] <= i_cmd_data[SAMPLE_BITS-1:0];
        r_coef_rd <= r_coef_mem[AW'(r_k)];
        r_hist_rd <= r_hist_mem[r_rdptr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_p1_ok ? s_mult : '0;
        if (s_start) begin
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc + ACCW'(r_prod);
        end
        if (s_start) r_last <= i_cmd.last;
        if (s_load) begin
            r_filtered  <= SAMPLE_BITS'(s_clip);
            r_saturated <= s_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= firrs_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_wptr      <= '0;
            r_rdptr     <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_n         <= '0;
            r_p1_vld    <= 1'b0;
            r_p1_ok     <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= s_issue;
            r_p1_ok  <= s_issue && (32'(r_k) <= 32'(r_fill));
            r_p2_vld <= r_p1_vld;
            if (s_coef_we && r_state == firrs_pkg::BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (s_start) begin
                r_k     <= '0;
                r_n     <= s_n;
                r_rdptr <= r_wptr;
                r_wptr  <= (r_wptr == AW'(TAPS - 1)) ? '0 : r_wptr + 1'b1;
            end else if (s_issue) begin
                r_k     <= r_k + 1'b1;
                r_rdptr <= (r_rdptr == '0) ? AW'(TAPS - 1) : r_rdptr - 1'b1;
            end
            if (s_load) begin
                // fill = prior samples of this block still held
                if (r_last) begin
                    r_fill <= '0;
                end else if (r_fill != AW'(TAPS - 1)) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
